@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define FMC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define FMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ hdl/fmc_pkg.sv @@
// ----------------------------------------------------------------------------
// fmc_pkg
// Constants and tables for the focal mechanism correlation unit.
// ----------------------------------------------------------------------------
package fmc_pkg;
	localparam int ANGLE_FRAC_BITS_DEF = 8;
	localparam int INNER_FRAC_BITS_DEF = 16;
	localparam int CORDIC_STAGES_DEF   = 16;

	localparam int STRIKE_W = 17;
	localparam int DIP_W    = 15;
	localparam int RAKE_W   = 17;
	localparam int CORR_W   = 16;
	localparam int ANG_W    = 18;
	localparam int IN_W     = 104;

	localparam int DEG2RAD_W = 27;
	localparam logic [DEG2RAD_W-1:0] DEG2RAD_Q32 = 27'd74961321;
	localparam logic [31:0] GAIN_Q30 = 32'd652032874;

	localparam logic [31:0] ATAN_Q30 [30] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
	};
endpackage

@@ hdl/focal_mechanism_correlation_unit.sv @@
// ----------------------------------------------------------------------------
// focal_mechanism_correlation_unit
// Correlation of fault normals and slip vectors of two focal mechanisms.
// ----------------------------------------------------------------------------
// Input stream s_*: one word holds strike, dip and rake of mechanisms a and b.
// Output stream m_*: one word holds the Q1.15 correlation.
// Each of the six angles runs through its own chain of CORDIC_STAGES cells.
// Throughput: one word per cycle while s_tready is high.
// From the accepting edge the word crosses the angle preparation (3
// registers, the first loaded at that edge), the CORDIC cells, the vector
// stages (5), the dot product stages (3) and the output register, where
// m_tvalid rises.
// A skid register behind the output lets the pipeline move one more word
// while m_tready is low; once it is full s_tready drops and the whole
// pipeline holds until the receiver takes a word.
// Reset empties the pipeline and output; no result is pending afterwards.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module focal_mechanism_correlation_unit #(
	parameter int ANGLE_FRAC_BITS = fmc_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int INNER_FRAC_BITS = fmc_pkg::INNER_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = fmc_pkg::CORDIC_STAGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// strike_a, dip_a, rake_a, strike_b, dip_b, rake_b, zero fill
	input  logic [fmc_pkg::IN_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// correlation
	output logic [fmc_pkg::CORR_W-1:0]   m_tdata
);
	localparam int W   = INNER_FRAC_BITS + 3;
	localparam int PW  = 2 * W;
	localparam int L   = CORDIC_STAGES + 11;
	localparam int SH2 = 2 * INNER_FRAC_BITS - 15;
	localparam logic [31:0] GAIN_SH = fmc_pkg::GAIN_Q30 >> (30 - INNER_FRAC_BITS);
	localparam logic signed [W-1:0] GAIN = W'(GAIN_SH);

	logic                           en;
	logic [L-1:0]                   vld_q;
	logic                           skid_v_q;
	logic [fmc_pkg::CORR_W-1:0]     skid_q;
	logic signed [fmc_pkg::ANG_W-1:0] ang [6];
	logic signed [W-1:0]            xc [6][CORDIC_STAGES+1];
	logic signed [W-1:0]            yc [6][CORDIC_STAGES+1];
	logic signed [W-1:0]            zc [6][CORDIC_STAGES+1];
	logic [1:0]                     qc [6][CORDIC_STAGES+1];
	logic signed [W-1:0]            na [3], ta [3], nb [3], tb [3];
	logic signed [PW-1:0]           np_s1 [3], tp_s1 [3];
	logic signed [W-1:0]            nc_s2, tc_s2;
	logic signed [PW-1:0]           r_s3;
	logic signed [PW+2:0]           nsum, tsum, ns_r, ts_r;
	logic signed [PW:0]             rr;
	logic [fmc_pkg::CORR_W-1:0]     res;

	assign en       = !skid_v_q;
	assign s_tready = en;

	assign ang[0] = $signed({1'b0, s_tdata[16:0]});
	assign ang[1] = $signed({3'b000, s_tdata[31:17]});
	assign ang[2] = $signed({s_tdata[48], s_tdata[48:32]});
	assign ang[3] = $signed({1'b0, s_tdata[65:49]});
	assign ang[4] = $signed({3'b000, s_tdata[80:66]});
	assign ang[5] = $signed({s_tdata[97], s_tdata[97:81]});

	for (genvar a = 0; a < 6; a++) begin : g_ang
		fmc_angle_prep #(.AFB(ANGLE_FRAC_BITS), .IFB(INNER_FRAC_BITS), .W(W)) u_prep (
			.clk(clk), .en(en), .ang(ang[a]), .z(zc[a][0]), .q(qc[a][0])
		);
		assign xc[a][0] = GAIN;
		assign yc[a][0] = '0;
		for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
			fmc_cordic_cell #(.W(W), .IFB(INNER_FRAC_BITS), .STAGE(i)) u_cell (
				.clk(clk), .en(en),
				.x_i(xc[a][i]), .y_i(yc[a][i]), .z_i(zc[a][i]), .q_i(qc[a][i]),
				.x_o(xc[a][i+1]), .y_o(yc[a][i+1]), .z_o(zc[a][i+1]), .q_o(qc[a][i+1])
			);
		end
	end

	fmc_vectors #(.W(W), .IFB(INNER_FRAC_BITS)) u_vec_a (
		.clk(clk), .en(en),
		.xs(xc[0][CORDIC_STAGES]), .ys(yc[0][CORDIC_STAGES]),
		.xd(xc[1][CORDIC_STAGES]), .yd(yc[1][CORDIC_STAGES]),
		.xr(xc[2][CORDIC_STAGES]), .yr(yc[2][CORDIC_STAGES]),
		.qs(qc[0][CORDIC_STAGES]), .qd(qc[1][CORDIC_STAGES]), .qr(qc[2][CORDIC_STAGES]),
		.n0(na[0]), .n1(na[1]), .n2(na[2]), .t0(ta[0]), .t1(ta[1]), .t2(ta[2])
	);

	fmc_vectors #(.W(W), .IFB(INNER_FRAC_BITS)) u_vec_b (
		.clk(clk), .en(en),
		.xs(xc[3][CORDIC_STAGES]), .ys(yc[3][CORDIC_STAGES]),
		.xd(xc[4][CORDIC_STAGES]), .yd(yc[4][CORDIC_STAGES]),
		.xr(xc[5][CORDIC_STAGES]), .yr(yc[5][CORDIC_STAGES]),
		.qs(qc[3][CORDIC_STAGES]), .qd(qc[4][CORDIC_STAGES]), .qr(qc[5][CORDIC_STAGES]),
		.n0(nb[0]), .n1(nb[1]), .n2(nb[2]), .t0(tb[0]), .t1(tb[1]), .t2(tb[2])
	);

	always_comb begin
		nsum = (PW+3)'(np_s1[0]) + (PW+3)'(np_s1[1]) + (PW+3)'(np_s1[2]);
		tsum = (PW+3)'(tp_s1[0]) + (PW+3)'(tp_s1[1]) + (PW+3)'(tp_s1[2]);
		ns_r = (nsum + (PW+3)'(1 << (INNER_FRAC_BITS - 1))) >>> INNER_FRAC_BITS;
		ts_r = (tsum + (PW+3)'(1 << (INNER_FRAC_BITS - 1))) >>> INNER_FRAC_BITS;
		rr   = ($signed({r_s3[PW-1], r_s3}) + (PW+1)'(1 << (SH2 - 1))) >>> SH2;
		if (rr > (PW+1)'(32767))
			res = 16'h7FFF;
		else if (rr < -(PW+1)'(32768))
			res = 16'h8000;
		else
			res = rr[15:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				np_s1[k] <= PW'(na[k]) * PW'(nb[k]);
				tp_s1[k] <= PW'(ta[k]) * PW'(tb[k]);
			end
			nc_s2 <= W'(ns_r);
			tc_s2 <= W'(ts_r);
			r_s3  <= PW'(nc_s2) * PW'(tc_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			skid_v_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (en)
				vld_q <= {vld_q[L-2:0], s_tvalid};
			if (skid_v_q) begin
				if (m_tready)
					skid_v_q <= 1'b0;
			end else if (vld_q[L-1]) begin
				if (!m_tvalid || m_tready)
					m_tvalid <= 1'b1;
				else
					skid_v_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_tready)
				m_tdata <= skid_q;
		end else if (vld_q[L-1]) begin
			if (!m_tvalid || m_tready)
				m_tdata <= res;
			else
				skid_q <= res;
		end
	end

	`FMC_ASSERT_IMPL(a_skid_out, clk, arst_n, skid_v_q, m_tvalid, "skid word without output word")
	`FMC_ASSERT_NEXT(a_skid_hold, clk, arst_n, skid_v_q && !m_tready, skid_v_q, "skid word lost")
	`FMC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
endmodule

@@ hdl/fmc_angle_prep.sv @@
// ----------------------------------------------------------------------------
// fmc_angle_prep
// Reduces an angle modulo 360 degrees, splits off the quadrant and converts
// the residue to radians for the CORDIC chain.
// ----------------------------------------------------------------------------
module fmc_angle_prep #(
	parameter int AFB = fmc_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int IFB = fmc_pkg::INNER_FRAC_BITS_DEF,
	parameter int W   = fmc_pkg::INNER_FRAC_BITS_DEF + 3
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [fmc_pkg::ANG_W-1:0] ang,
	output logic signed [W-1:0]             z,
	output logic [1:0]                      q
);
	localparam int FULL    = 360 << AFB;
	localparam int QUARTER = 90 << AFB;
	localparam int HALFQ   = 45 << AFB;
	localparam int OFF     = ((65536 + FULL - 1) / FULL) * FULL;
	localparam int RW      = 27;
	localparam int RBW     = $clog2(FULL);
	localparam int REMW    = RBW + 2;
	localparam int MW      = $clog2(HALFQ + 1);
	localparam int PRW     = MW + fmc_pkg::DEG2RAD_W + 1;
	localparam int SH      = 32 + AFB - IFB;

	logic [RW-1:0]          v;
	logic [RBW-1:0]         r_s1;
	logic [2:0]             qn;
	logic signed [REMW-1:0] rem;
	logic [MW-1:0]          mag_s2;
	logic                   neg_s2, neg_s3;
	logic [1:0]             q_s2, q_s3;
	logic [PRW-1:0]         prod_s3;
	logic [PRW-1:0]         zr;
	logic signed [W-1:0]    zmag;

	always_comb begin
		v = {{(RW-fmc_pkg::ANG_W){ang[fmc_pkg::ANG_W-1]}}, ang} + RW'(OFF);
		for (int k = 5; k >= 0; k--) begin
			if (v >= (RW'(FULL) << k))
				v = v - (RW'(FULL) << k);
		end
	end

	always_comb begin
		qn = 3'd0;
		for (int k = 0; k < 4; k++) begin
			if (r_s1 > RBW'(HALFQ + k * QUARTER))
				qn = qn + 3'd1;
		end
		rem = $signed({2'b00, r_s1}) - $signed(REMW'(int'(qn) * QUARTER));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= RBW'(v);
			mag_s2  <= rem[REMW-1] ? MW'(-rem) : MW'(rem);
			neg_s2  <= rem[REMW-1];
			q_s2    <= qn[1:0];
			prod_s3 <= PRW'(mag_s2) * PRW'(fmc_pkg::DEG2RAD_Q32);
			neg_s3  <= neg_s2;
			q_s3    <= q_s2;
		end
	end

	assign zr   = (prod_s3 + (PRW'(1) << (SH - 1))) >> SH;
	assign zmag = $signed(W'(zr));
	assign z    = neg_s3 ? -zmag : zmag;
	assign q    = q_s3;
endmodule

@@ hdl/fmc_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// fmc_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module fmc_cordic_cell #(
	parameter int W     = fmc_pkg::INNER_FRAC_BITS_DEF + 3,
	parameter int IFB   = fmc_pkg::INNER_FRAC_BITS_DEF,
	parameter int STAGE = 0
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] x_i,
	input  logic signed [W-1:0] y_i,
	input  logic signed [W-1:0] z_i,
	input  logic [1:0]          q_i,
	output logic signed [W-1:0] x_o,
	output logic signed [W-1:0] y_o,
	output logic signed [W-1:0] z_o,
	output logic [1:0]          q_o
);
	localparam logic [31:0] ATAN_SH = fmc_pkg::ATAN_Q30[STAGE] >> (30 - IFB);
	localparam logic signed [W-1:0] ATAN_I = W'(ATAN_SH);

	logic signed [W-1:0] dx, dy;

	assign dx = y_i >>> STAGE;
	assign dy = x_i >>> STAGE;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_i[W-1]) begin
				x_o <= x_i - dx;
				y_o <= y_i + dy;
				z_o <= z_i - ATAN_I;
			end else begin
				x_o <= x_i + dx;
				y_o <= y_i - dy;
				z_o <= z_i + ATAN_I;
			end
			q_o <= q_i;
		end
	end
endmodule

@@ hdl/fmc_vectors.sv @@
// ----------------------------------------------------------------------------
// fmc_vectors
// Builds fault normal and slip vector of one mechanism from CORDIC results.
// ----------------------------------------------------------------------------
module fmc_vectors #(
	parameter int W   = fmc_pkg::INNER_FRAC_BITS_DEF + 3,
	parameter int IFB = fmc_pkg::INNER_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] xs, ys, xd, yd, xr, yr,
	input  logic [1:0]          qs, qd, qr,
	output logic signed [W-1:0] n0, n1, n2, t0, t1, t2
);
	localparam int PW = 2 * W;

	function automatic logic signed [W-1:0] rnd_p(input logic signed [PW-1:0] p);
		logic signed [PW:0] t;
		t = {p[PW-1], p} + (PW+1)'(1 << (IFB - 1));
		return W'(t >>> IFB);
	endfunction

	function automatic logic signed [2*W-1:0] quad(input logic signed [W-1:0] x,
		input logic signed [W-1:0] y, input logic [1:0] q);
		logic signed [2*W-1:0] cs;
		unique case (q)
			2'd0: cs = {x, y};
			2'd1: cs = {-y, x};
			2'd2: cs = {-x, -y};
			default: cs = {y, -x};
		endcase
		return cs;
	endfunction

	logic signed [W-1:0] cs_s1, ss_s1, cd_s1, sd_s1, cr_s1, sr_s1;
	logic signed [PW-1:0] sdss_s2, sdcs_s2, cdss_s2, cdcs_s2;
	logic signed [W-1:0] cs_s2, ss_s2, cd_s2, sd_s2, cr_s2, sr_s2;
	logic signed [W-1:0] n0_s3, n1_s3, n2_s3, rd0_s3, rd1_s3, rd2_s3;
	logic signed [W-1:0] cs_s3, ss_s3, cr_s3, sr_s3;
	logic signed [PW-1:0] cscr_s4, sscr_s4, rd0sr_s4, rd1sr_s4, rd2sr_s4;
	logic signed [W-1:0] n0_s4, n1_s4, n2_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			{cs_s1, ss_s1} <= quad(xs, ys, qs);
			{cd_s1, sd_s1} <= quad(xd, yd, qd);
			{cr_s1, sr_s1} <= quad(xr, yr, qr);

			sdss_s2 <= PW'(sd_s1) * PW'(ss_s1);
			sdcs_s2 <= PW'(sd_s1) * PW'(cs_s1);
			cdss_s2 <= PW'(cd_s1) * PW'(ss_s1);
			cdcs_s2 <= PW'(cd_s1) * PW'(cs_s1);
			cs_s2 <= cs_s1; ss_s2 <= ss_s1; cd_s2 <= cd_s1;
			sd_s2 <= sd_s1; cr_s2 <= cr_s1; sr_s2 <= sr_s1;

			n0_s3  <= -rnd_p(sdss_s2);
			n1_s3  <= rnd_p(sdcs_s2);
			n2_s3  <= -cd_s2;
			rd0_s3 <= -rnd_p(cdss_s2);
			rd1_s3 <= rnd_p(cdcs_s2);
			rd2_s3 <= sd_s2;
			cs_s3 <= cs_s2; ss_s3 <= ss_s2; cr_s3 <= cr_s2; sr_s3 <= sr_s2;

			cscr_s4  <= PW'(cs_s3) * PW'(cr_s3);
			sscr_s4  <= PW'(ss_s3) * PW'(cr_s3);
			rd0sr_s4 <= PW'(rd0_s3) * PW'(sr_s3);
			rd1sr_s4 <= PW'(rd1_s3) * PW'(sr_s3);
			rd2sr_s4 <= PW'(rd2_s3) * PW'(sr_s3);
			n0_s4 <= n0_s3; n1_s4 <= n1_s3; n2_s4 <= n2_s3;

			t0 <= rnd_p(cscr_s4) - rnd_p(rd0sr_s4);
			t1 <= rnd_p(sscr_s4) - rnd_p(rd1sr_s4);
			t2 <= -rnd_p(rd2sr_s4);
			n0 <= n0_s4; n1 <= n1_s4; n2 <= n2_s4;
		end
	end
endmodule
